// ----- design/weighted_improvement_score_table_macros.svh -----
// Assertion macros shared by the score table RTL.
// Needs nothing else; the user passes clock, active-low reset and message.
`ifndef WEIGHTED_IMPROVEMENT_SCORE_TABLE_MACROS_SVH
`define WEIGHTED_IMPROVEMENT_SCORE_TABLE_MACROS_SVH

// Same-cycle implication.
`define WIST_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WIST_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wist_pkg.sv -----
// Shared types and codes of the weighted improvement score table.
// No dependencies; used by the top-level module of the block.
package wist_pkg;

    localparam int DATA_W    = 32;
    localparam int SCORE_W   = 40;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W     = 8;
    localparam int Q_FRAC    = 8;
    localparam int CV_W      = 5;
    localparam int PROB_W    = 16;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
    localparam logic [CV_W-1:0]  CV_RESET = 5'd4;
    localparam logic [SCORE_W-1:0] ONE_Q8 = 40'd256;

    // item modes
    localparam logic [1:0] MODE_RECORD   = 2'd0;
    localparam logic [1:0] MODE_ESTIMATE = 2'd1;
    localparam logic [1:0] MODE_BEGIN    = 2'd2;
    localparam logic [1:0] MODE_END      = 2'd3;

    // result status codes
    localparam logic [2:0] ST_AVERAGE = 3'd0;
    localparam logic [2:0] ST_NEVER   = 3'd1;
    localparam logic [2:0] ST_NOGAIN  = 3'd2;
    localparam logic [2:0] ST_EXPLORE = 3'd3;
    localparam logic [2:0] ST_ACK     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONSIDERED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE   = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [2:0]               alg_id;
        logic [1:0]               conf_id;
        logic signed [DATA_W-1:0] start_value;
        logic signed [DATA_W-1:0] end_value;
        logic [PROB_W-1:0]        random_draw;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [SCORE_W-1:0] score;
    } result_t;

endpackage

// ----- design/wist_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/wist_div.sv -----
// Restoring divider, two quotient bits per cycle.
// No dependencies; used by the score table for the weighted mean.
module wist_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            num_next = PAD_W'(num);
            rem_next = '0;
            cnt_next = CNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            for (int i = 0; i < 2; i++)
            begin
                trial    = {rem_next, num_next[PAD_W-1]};
                num_next = {num_next[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, den})
                begin
                    trial       = trial - {1'b0, den};
                    num_next[0] = 1'b1;
                end
                rem_next = trial[DEN_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg[NUM_W-1:0];

endmodule

// ----- design/weighted_improvement_score_table.sv -----
// Weighted improvement score table: top level.
// Depends on wist_pkg, wist_ram, wist_div and the assertion macro header.
//
// One item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be held
// off. For record, begin and end items, and for estimates answered without an
// average, the per-entry word is read from the metadata RAM in the accept
// cycle and written back in the next, and the result shows in the cycle
// after, in which the next item can already be taken. An averaged estimate
// walks the history RAM one word per cycle and then runs a radix-4 divider.
// The block needs no clearing pass after reset; per-entry valid bits stand
// in.
`include "weighted_improvement_score_table_macros.svh"

module weighted_improvement_score_table #(
    parameter int NUM_ALGS   = 8,
    parameter int NUM_CONFS  = 4,
    parameter int HIST_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  wist_pkg::item_t                      item,
    output logic                                 done,
    output wist_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [wist_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wist_pkg::CFG_W-1:0]           cfg_data
);

    localparam int ENTRIES  = NUM_ALGS * NUM_CONFS;
    localparam int ENT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_W   = $clog2(HIST_DEPTH + 1);
    localparam int RUN_W    = wist_pkg::RUN_W;
    localparam int META_W   = RUN_W + FILL_W + PTR_W;
    localparam int HDEPTH   = ENTRIES * HIST_DEPTH;
    localparam int HADDR_W  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int WSUM_MAX = HIST_DEPTH * (HIST_DEPTH + 1) / 2;
    localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
    localparam int DATA_W   = wist_pkg::DATA_W;
    localparam int SUM_W    = DATA_W + FILL_W;
    localparam int ACC_W    = DATA_W + WSUM_W;
    localparam int NUM_W    = ACC_W + wist_pkg::Q_FRAC;
    localparam int SCORE_W  = wist_pkg::SCORE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_META = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;

    typedef struct packed {
        logic [RUN_W-1:0]  run;
        logic [FILL_W-1:0] fill;
        logic [PTR_W-1:0]  ptr;
    } meta_t;

    // configuration
    logic [wist_pkg::CV_W-1:0]   cv_reg;
    logic [wist_pkg::PROB_W-1:0] prob_reg;
    logic [DATA_W-1:0]           restart_reg;
    logic                        max_reg;

    // control
    logic [2:0]          state_reg, state_next;
    logic                done_reg, done_next;
    wist_pkg::result_t   result_reg, result_next;
    logic [DATA_W-1:0]   term_reg, term_next;
    logic [ENTRIES-1:0]  meta_valid;
    logic [ENTRIES-1:0]  hist_valid;

    // latched item
    wist_pkg::item_t     item_reg;
    logic [ENT_W-1:0]    ent_reg;
    logic                inr_reg;

    // walk and divide
    logic [FILL_W-1:0]   iss_reg, iss_next;
    logic [FILL_W-1:0]   n_reg, n_next;
    logic [PTR_W-1:0]    slot_reg, slot_next;
    logic                rv_reg, rv_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [HADDR_W-1:0]  hbase_reg, hbase_next;

    // comb
    logic                accept;
    logic [ENT_W-1:0]    ent_in;
    logic                inr_in;
    meta_t               meta_rd, meta_wr, meta_cur;
    logic                meta_we;
    logic [ENT_W-1:0]    meta_raddr;
    logic                hist_we;
    logic [HADDR_W-1:0]  hist_waddr, hist_raddr, hbase_cur;
    logic [DATA_W-1:0]   hist_wdata, hist_rd;
    logic [PTR_W-1:0]    ptr_inc, ptr_dec;
    logic [FILL_W-1:0]   cv_eff, nsel;
    logic signed [DATA_W:0] gain;
    logic                restart_hit;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [SUM_W-1:0]    sum_acc;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign inr_in = (int'(item.alg_id) < NUM_ALGS) && (int'(item.conf_id) < NUM_CONFS);
    assign ent_in = ENT_W'(int'(item.alg_id) * NUM_CONFS + int'(item.conf_id));
    assign meta_raddr = inr_in ? ent_in : '0;

    wist_ram #(
        .WIDTH (META_W),
        .DEPTH (ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (ent_reg),
        .wdata (meta_wr),
        .raddr (meta_raddr),
        .rdata (meta_rd)
    );

    wist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rd)
    );

    wist_div #(
        .NUM_W (NUM_W),
        .DEN_W (WSUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({acc_reg, {wist_pkg::Q_FRAC{1'b0}}}),
        .den   (wsum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // entry word as seen through the valid bits; a restart hides fill and pointer
    always_comb
    begin
        meta_cur = '0;
        if (meta_valid[ent_reg])
        begin
            meta_cur.run = meta_rd.run;
            if (hist_valid[ent_reg])
            begin
                meta_cur.fill = meta_rd.fill;
                meta_cur.ptr  = meta_rd.ptr;
            end
        end
    end

    assign ptr_inc = (meta_cur.ptr == PTR_W'(HIST_DEPTH - 1)) ? '0 : meta_cur.ptr + 1'b1;
    assign ptr_dec = (meta_cur.ptr == '0) ? PTR_W'(HIST_DEPTH - 1) : meta_cur.ptr - 1'b1;
    assign cv_eff  = (32'(cv_reg) > 32'(HIST_DEPTH)) ? FILL_W'(HIST_DEPTH)
                                                    : FILL_W'(cv_reg);
    assign nsel    = (cv_eff < meta_cur.fill) ? cv_eff : meta_cur.fill;
    assign hbase_cur = HADDR_W'(int'(ent_reg) * HIST_DEPTH);
    assign hist_raddr = hbase_reg + HADDR_W'(slot_reg);
    assign sum_acc = sum_reg + SUM_W'(hist_rd);

    // gain at 33 bits never exceeds 32 unsigned bits once clamped at zero
    assign gain = max_reg
        ? ($signed({item_reg.end_value[DATA_W-1], item_reg.end_value})
           - $signed({item_reg.start_value[DATA_W-1], item_reg.start_value}))
        : ($signed({item_reg.start_value[DATA_W-1], item_reg.start_value})
           - $signed({item_reg.end_value[DATA_W-1], item_reg.end_value}));

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        term_next   = term_reg;
        restart_hit = 1'b0;
        meta_we     = 1'b0;
        meta_wr     = meta_cur;
        hist_we     = 1'b0;
        hist_waddr  = hbase_cur + HADDR_W'(meta_cur.ptr);
        hist_wdata  = gain[DATA_W] ? '0 : gain[DATA_W-1:0];
        iss_next    = iss_reg;
        n_next      = n_reg;
        slot_next   = slot_reg;
        rv_next     = 1'b0;
        sum_next    = sum_reg;
        acc_next    = acc_reg;
        wsum_next   = wsum_reg;
        hbase_next  = hbase_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                result_next.status = wist_pkg::ST_ACK;
                result_next.score  = '0;
                if (!inr_reg)
                begin
                    if (item_reg.mode == wist_pkg::MODE_ESTIMATE)
                    begin
                        result_next.status = wist_pkg::ST_NEVER;
                    end
                end
                else
                begin
                    unique case (item_reg.mode)
                        wist_pkg::MODE_RECORD:
                        begin
                            if (item_reg.start_value != '0)
                            begin
                                hist_we      = 1'b1;
                                meta_we      = 1'b1;
                                meta_wr.ptr  = ptr_inc;
                                if (meta_cur.fill < FILL_W'(HIST_DEPTH))
                                begin
                                    meta_wr.fill = meta_cur.fill + 1'b1;
                                end
                            end
                        end
                        wist_pkg::MODE_ESTIMATE:
                        begin
                            if (meta_cur.fill == '0)
                            begin
                                result_next.status = (meta_cur.run == '0)
                                    ? wist_pkg::ST_NEVER : wist_pkg::ST_NOGAIN;
                            end
                            else if (item_reg.random_draw < prob_reg)
                            begin
                                result_next.status = wist_pkg::ST_EXPLORE;
                                result_next.score  = wist_pkg::ONE_Q8;
                            end
                            else if (nsel == '0)
                            begin
                                result_next.status = wist_pkg::ST_NOGAIN;
                            end
                            else
                            begin
                                // newest first: running sum S, acc += S weights newest by n
                                done_next  = 1'b0;
                                state_next = S_WALK;
                                iss_next   = '0;
                                n_next     = nsel;
                                slot_next  = ptr_dec;
                                sum_next   = '0;
                                acc_next   = '0;
                                hbase_next = hbase_cur;
                                wsum_next  = WSUM_W'((32'(nsel) * (32'(nsel) + 32'd1)) >> 1);
                            end
                        end
                        wist_pkg::MODE_BEGIN:
                        begin
                            meta_we = 1'b1;
                            if (meta_cur.run != wist_pkg::RUN_MAX)
                            begin
                                meta_wr.run = meta_cur.run + 1'b1;
                            end
                        end
                        wist_pkg::MODE_END:
                        begin
                            meta_we = 1'b1;
                            if (meta_cur.run != '0)
                            begin
                                meta_wr.run = meta_cur.run - 1'b1;
                            end
                            term_next   = term_reg + 1'b1;
                            restart_hit = (restart_reg != '0) && (term_next == restart_reg);
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (iss_reg < n_reg)
                begin
                    iss_next  = iss_reg + 1'b1;
                    slot_next = (slot_reg == '0) ? PTR_W'(HIST_DEPTH - 1) : slot_reg - 1'b1;
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    sum_next = sum_acc;
                    acc_next = acc_reg + ACC_W'(sum_acc);
                end
                else if (iss_reg == n_reg)
                begin
                    if (acc_reg == '0)
                    begin
                        state_next         = S_IDLE;
                        done_next          = 1'b1;
                        result_next.status = wist_pkg::ST_NOGAIN;
                        result_next.score  = '0;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.status = wist_pkg::ST_AVERAGE;
                    result_next.score  = SCORE_W'(div_quot);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            term_reg    <= '0;
            meta_valid  <= '0;
            hist_valid  <= '0;
            rv_reg      <= 1'b0;
            iss_reg     <= '0;
            n_reg       <= '0;
            cv_reg      <= wist_pkg::CV_RESET;
            prob_reg    <= '0;
            restart_reg <= '0;
            max_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            term_reg  <= term_next;
            rv_reg    <= rv_next;
            iss_reg   <= iss_next;
            n_reg     <= n_next;
            if (meta_we)
            begin
                meta_valid[ent_reg] <= 1'b1;
            end
            // a restart drops every history, the entry just written included
            if (restart_hit)
            begin
                hist_valid <= '0;
            end
            else if (meta_we)
            begin
                hist_valid[ent_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wist_pkg::REG_CONSIDERED: cv_reg      <= cfg_data[wist_pkg::CV_W-1:0];
                    wist_pkg::REG_EXPLORE:    prob_reg    <= cfg_data[wist_pkg::PROB_W-1:0];
                    wist_pkg::REG_RESTART:    restart_reg <= cfg_data[DATA_W-1:0];
                    wist_pkg::REG_MAXIMIZE:   max_reg     <= cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        slot_reg   <= slot_next;
        sum_reg    <= sum_next;
        acc_reg    <= acc_next;
        wsum_reg   <= wsum_next;
        hbase_reg  <= hbase_next;
        if (accept)
        begin
            item_reg <= item;
            ent_reg  <= ent_in;
            inr_reg  <= inr_in;
        end
    end

    `WIST_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not make the block busy")
    `WIST_ASSERT_IMPL(a_done_after_work, clk, rst_n, done, $past(busy), "result strobe without work in progress")
    `WIST_ASSERT_IMPL(a_explore_score, clk, rst_n, done && result.status == wist_pkg::ST_EXPLORE, result.score == wist_pkg::ONE_Q8, "explore result carries wrong score")
    `WIST_ASSERT_IMPL(a_walk_bound, clk, rst_n, state_reg == S_WALK, iss_reg <= n_reg, "history walk ran past the considered gains")

endmodule
